// ===== rtl/core/tcp_flow_tracking_table_core_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the flow tracking table core
// ---------------------------------------------------------------------------
`ifndef TCP_FLOW_TRACKING_TABLE_CORE_ASSERT_SVH
`define TCP_FLOW_TRACKING_TABLE_CORE_ASSERT_SVH

// same-cycle implication
`define TFLT_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tflt assertion failed");

// next-cycle implication
`define TFLT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tflt assertion failed");

`endif

// ===== rtl/core/tflt_pkg.sv =====
// ---------------------------------------------------------------------------
// tflt_pkg
// Shared types and constants of the TCP flow tracking table.
// ---------------------------------------------------------------------------
package tflt_pkg;

    localparam logic [31:0] DEFAULT_TIMEOUT = 32'd300;
    localparam int          MAX_RESULTS     = 16;

    localparam int FLAG_FIN_BIT = 0;
    localparam int FLAG_SYN_BIT = 1;
    localparam int FLAG_RST_BIT = 2;
    localparam int FLAG_ACK_BIT = 4;

    localparam logic [2:0] KIND_UNTRACKED = 3'd0;
    localparam logic [2:0] KIND_UPDATED   = 3'd1;
    localparam logic [2:0] KIND_CLOSED    = 3'd2;
    localparam logic [2:0] KIND_TIMEOUT   = 3'd3;
    localparam logic [2:0] KIND_FULL      = 3'd4;

    localparam logic CMD_PACKET = 1'b0;
    localparam logic CMD_SWEEP  = 1'b1;

    typedef struct packed {
        logic [31:0] sa;
        logic [31:0] da;
        logic [15:0] sp;
        logic [15:0] dp;
        logic        active;
        logic [31:0] spk;
        logic [31:0] rpk;
        logic [63:0] sb;
        logic [63:0] rb;
    } entry_t;

    typedef struct packed {
        logic capture;
        logic cmp;
        logic sel;
        logic upd;
        logic emit_pkt;
        logic sw_next;
        logic emit_sw;
    } ctrl_cmd_t;

    typedef struct packed {
        logic is_sweep;
        logic hit;
        logic free_any;
        logic syn;
        logic mask_empty;
        logic last;
        logic out_free;
    } ctrl_sts_t;

endpackage

// ===== rtl/core/tflt_if.sv =====
// ---------------------------------------------------------------------------
// tflt interfaces
// Packet input, record output and timeout configuration channels.
// ---------------------------------------------------------------------------
interface tflt_pkt_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [31:0] now_seconds;
    logic [31:0] source_address;
    logic [31:0] destination_address;
    logic [15:0] source_port;
    logic [15:0] destination_port;
    logic [15:0] ip_total_length;
    logic [7:0]  tcp_flag_bits;

    modport source (output valid, command, now_seconds, source_address,
                    destination_address, source_port, destination_port,
                    ip_total_length, tcp_flag_bits, input ready);
    modport sink (input valid, command, now_seconds, source_address,
                  destination_address, source_port, destination_port,
                  ip_total_length, tcp_flag_bits, output ready);
endinterface

interface tflt_rec_if;
    logic        valid;
    logic        ready;
    logic [2:0]  record_kind;
    logic [3:0]  slot_index;
    logic [31:0] flow_source_address;
    logic [31:0] flow_destination_address;
    logic [15:0] flow_source_port;
    logic [15:0] flow_destination_port;
    logic        opened_actively;
    logic [31:0] sent_packet_count;
    logic [31:0] received_packet_count;
    logic [63:0] sent_byte_count;
    logic [63:0] received_byte_count;
    logic        last_in_run;

    modport source (output valid, record_kind, slot_index, flow_source_address,
                    flow_destination_address, flow_source_port,
                    flow_destination_port, opened_actively, sent_packet_count,
                    received_packet_count, sent_byte_count, received_byte_count,
                    last_in_run, input ready);
    modport sink (input valid, record_kind, slot_index, flow_source_address,
                  flow_destination_address, flow_source_port,
                  flow_destination_port, opened_actively, sent_packet_count,
                  received_packet_count, sent_byte_count, received_byte_count,
                  last_in_run, output ready);
endinterface

interface tflt_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] idle_timeout_seconds;

    modport source (output valid, idle_timeout_seconds, input ready);
    modport sink (input valid, idle_timeout_seconds, output ready);
endinterface

// ===== rtl/core/tflt_ram.sv =====
// ---------------------------------------------------------------------------
// tflt_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module tflt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

// ===== rtl/core/tflt_ctrl.sv =====
// ---------------------------------------------------------------------------
// tflt_ctrl
// Sequencer for lookup, update and aging sweep.
// ---------------------------------------------------------------------------
`include "tcp_flow_tracking_table_core_assert.svh"

module tflt_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  tflt_pkg::ctrl_sts_t sts,
    output tflt_pkg::ctrl_cmd_t cmd
);

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_CMP    = 9'b000000010,
        S_SEL    = 9'b000000100,
        S_RD     = 9'b000001000,
        S_UPD    = 9'b000010000,
        S_EPKT   = 9'b000100000,
        S_SWNXT  = 9'b001000000,
        S_SWRD   = 9'b010000000,
        S_SWEMIT = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_CMP;
                end
            end
            S_CMP:
            begin
                cmd.cmp    = 1'b1;
                state_next = sts.is_sweep ? S_SWNXT : S_SEL;
            end
            S_SEL:
            begin
                cmd.sel    = 1'b1;
                state_next = (sts.hit || (sts.syn && sts.free_any)) ? S_RD : S_EPKT;
            end
            S_RD:
            begin
                state_next = S_UPD;
            end
            S_UPD:
            begin
                if (sts.out_free)
                begin
                    cmd.upd    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_EPKT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_pkt = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_SWNXT:
            begin
                if (sts.mask_empty)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.sw_next = 1'b1;
                    state_next  = S_SWRD;
                end
            end
            S_SWRD:
            begin
                state_next = S_SWEMIT;
            end
            S_SWEMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_sw = 1'b1;
                    state_next  = sts.last ? S_IDLE : S_SWNXT;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    `TFLT_ASSERT_NEXT(a_accept_to_cmp, clk, rst_n, in_valid && in_ready, state_reg == S_CMP)
    `TFLT_ASSERT_NOW(a_emit_needs_room, clk, rst_n, cmd.upd || cmd.emit_pkt || cmd.emit_sw, sts.out_free)
    `TFLT_ASSERT_NEXT(a_last_ends_sweep, clk, rst_n, cmd.emit_sw && sts.last, state_reg == S_IDLE)

endmodule

// ===== rtl/core/tflt_dp.sv =====
// ---------------------------------------------------------------------------
// tflt_dp
// Key compare cells, entry RAM, counter update and record register.
// ---------------------------------------------------------------------------
module tflt_dp #(
    parameter int TABLE_DEPTH = 16,
    parameter int IDXW        = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    tflt_pkt_if.sink            pkt,
    tflt_rec_if.source          rec,
    tflt_cfg_if.sink            cfg,
    input  tflt_pkg::ctrl_cmd_t cmd,
    output tflt_pkg::ctrl_sts_t sts
);

    localparam int CNTW = $clog2(tflt_pkg::MAX_RESULTS);

    // captured word
    logic        cmd_reg;
    logic [31:0] now_reg, sa_reg, da_reg;
    logic [15:0] sp_reg, dp_reg, len_reg;
    logic [7:0]  flg_reg;

    logic [31:0] timeout_reg;
    logic [TABLE_DEPTH-1:0] valid_reg, match_reg, free_reg, mask_reg;
    logic [31:0] key_sa_reg [TABLE_DEPTH];
    logic [31:0] key_da_reg [TABLE_DEPTH];
    logic [15:0] key_sp_reg [TABLE_DEPTH];
    logic [15:0] key_dp_reg [TABLE_DEPTH];
    logic [31:0] last_reg [TABLE_DEPTH];

    logic [IDXW-1:0] slot_reg;
    logic            hit_reg;
    logic            swlast_reg;
    logic [CNTW-1:0] swcnt_reg;

    logic [TABLE_DEPTH-1:0] match_c, idle_c, mask_rest;
    logic [IDXW-1:0]        match_idx, free_idx, mask_idx;

    tflt_pkg::entry_t rdata, base, upd_e;
    logic             dir_sent, fin_rst;

    logic        ov_reg;
    logic [2:0]  kind_reg;
    logic [3:0]  oslot_reg;
    tflt_pkg::entry_t oe_reg;
    logic        olast_reg;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            match_c[i] = valid_reg[i] &&
                ((key_sa_reg[i] == sa_reg && key_sp_reg[i] == sp_reg &&
                  key_da_reg[i] == da_reg && key_dp_reg[i] == dp_reg) ||
                 (key_sa_reg[i] == da_reg && key_sp_reg[i] == dp_reg &&
                  key_da_reg[i] == sa_reg && key_dp_reg[i] == sp_reg));
            idle_c[i] = valid_reg[i] && ((now_reg - last_reg[i]) > timeout_reg);
        end
    end

    always_comb
    begin
        match_idx = '0;
        free_idx  = '0;
        mask_idx  = '0;
        for (int i = TABLE_DEPTH - 1; i >= 0; i--)
        begin
            if (match_reg[i])
            begin
                match_idx = IDXW'(i);
            end
            if (free_reg[i])
            begin
                free_idx = IDXW'(i);
            end
            if (mask_reg[i])
            begin
                mask_idx = IDXW'(i);
            end
        end
    end

    assign mask_rest = mask_reg & (mask_reg - 1'b1);

    tflt_ram #(
        .WIDTH ($bits(tflt_pkg::entry_t)),
        .DEPTH (TABLE_DEPTH),
        .AW    (IDXW)
    ) u_ram (
        .clk   (clk),
        .we    (cmd.upd),
        .waddr (slot_reg),
        .wdata (upd_e),
        .raddr (slot_reg),
        .rdata (rdata)
    );

    always_comb
    begin
        if (hit_reg)
        begin
            base = rdata;
        end
        else
        begin
            base        = '0;
            base.sa     = sa_reg;
            base.da     = da_reg;
            base.sp     = sp_reg;
            base.dp     = dp_reg;
            base.active = !flg_reg[tflt_pkg::FLAG_ACK_BIT];
        end
        dir_sent = (base.sa == sa_reg) && (base.sp == sp_reg);
        upd_e    = base;
        if (dir_sent)
        begin
            upd_e.spk = base.spk + 32'd1;
            upd_e.sb  = base.sb + 64'(len_reg);
        end
        else
        begin
            upd_e.rpk = base.rpk + 32'd1;
            upd_e.rb  = base.rb + 64'(len_reg);
        end
    end

    assign fin_rst = flg_reg[tflt_pkg::FLAG_FIN_BIT] || flg_reg[tflt_pkg::FLAG_RST_BIT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= tflt_pkg::DEFAULT_TIMEOUT;
            valid_reg   <= '0;
            ov_reg      <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                timeout_reg <= cfg.idle_timeout_seconds;
            end
            if (cmd.upd)
            begin
                valid_reg[slot_reg] <= !fin_rst;
            end
            if (cmd.emit_sw)
            begin
                valid_reg[slot_reg] <= 1'b0;
            end
            if (cmd.upd || cmd.emit_pkt || cmd.emit_sw)
            begin
                ov_reg <= 1'b1;
            end
            else if (rec.ready)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            cmd_reg <= pkt.command;
            now_reg <= pkt.now_seconds;
            sa_reg  <= pkt.source_address;
            da_reg  <= pkt.destination_address;
            sp_reg  <= pkt.source_port;
            dp_reg  <= pkt.destination_port;
            len_reg <= pkt.ip_total_length;
            flg_reg <= pkt.tcp_flag_bits;
        end
        if (cmd.cmp)
        begin
            match_reg <= match_c;
            free_reg  <= ~valid_reg;
            mask_reg  <= idle_c;
            swcnt_reg <= '0;
        end
        if (cmd.sel)
        begin
            hit_reg  <= |match_reg;
            slot_reg <= (|match_reg) ? match_idx : free_idx;
        end
        if (cmd.sw_next)
        begin
            slot_reg   <= mask_idx;
            mask_reg   <= mask_rest;
            swlast_reg <= (mask_rest == '0) ||
                          (swcnt_reg == CNTW'(tflt_pkg::MAX_RESULTS - 1));
        end
        if (cmd.upd)
        begin
            key_sa_reg[slot_reg] <= upd_e.sa;
            key_da_reg[slot_reg] <= upd_e.da;
            key_sp_reg[slot_reg] <= upd_e.sp;
            key_dp_reg[slot_reg] <= upd_e.dp;
            last_reg[slot_reg]   <= now_reg;
            kind_reg  <= fin_rst ? tflt_pkg::KIND_CLOSED : tflt_pkg::KIND_UPDATED;
            oslot_reg <= 4'(slot_reg);
            oe_reg    <= upd_e;
            olast_reg <= 1'b1;
        end
        if (cmd.emit_pkt)
        begin
            kind_reg  <= flg_reg[tflt_pkg::FLAG_SYN_BIT] ? tflt_pkg::KIND_FULL
                                                         : tflt_pkg::KIND_UNTRACKED;
            oslot_reg <= '0;
            oe_reg    <= '{sa: sa_reg, da: da_reg, sp: sp_reg, dp: dp_reg, default: '0};
            olast_reg <= 1'b1;
        end
        if (cmd.emit_sw)
        begin
            kind_reg  <= tflt_pkg::KIND_TIMEOUT;
            oslot_reg <= 4'(slot_reg);
            oe_reg    <= rdata;
            olast_reg <= swlast_reg;
            swcnt_reg <= swcnt_reg + 1'b1;
        end
    end

    assign sts.is_sweep   = (cmd_reg == tflt_pkg::CMD_SWEEP);
    assign sts.hit        = |match_reg;
    assign sts.free_any   = |free_reg;
    assign sts.syn        = flg_reg[tflt_pkg::FLAG_SYN_BIT];
    assign sts.mask_empty = (mask_reg == '0);
    assign sts.last       = swlast_reg;
    assign sts.out_free   = !ov_reg || rec.ready;

    assign rec.valid                    = ov_reg;
    assign rec.record_kind              = kind_reg;
    assign rec.slot_index               = oslot_reg;
    assign rec.flow_source_address      = oe_reg.sa;
    assign rec.flow_destination_address = oe_reg.da;
    assign rec.flow_source_port         = oe_reg.sp;
    assign rec.flow_destination_port    = oe_reg.dp;
    assign rec.opened_actively          = oe_reg.active;
    assign rec.sent_packet_count        = oe_reg.spk;
    assign rec.received_packet_count    = oe_reg.rpk;
    assign rec.sent_byte_count          = oe_reg.sb;
    assign rec.received_byte_count      = oe_reg.rb;
    assign rec.last_in_run              = olast_reg;

endmodule

// ===== rtl/core/tcp_flow_tracking_table_core.sv =====
// ---------------------------------------------------------------------------
// tcp_flow_tracking_table_core
// TCP flow table keyed by 4-tuple with counters and aging sweep.
// ---------------------------------------------------------------------------
//  channel | dir | word
//  pkt     | in  | packet header or sweep command
//  rec     | out | flow record
//  cfg     | in  | idle timeout
//
// Packet: compare, select, RAM read and update run from accept to record;
// untracked or table full skips the RAM read and update. Ready is high only
// while idle. Sweep: compare, then next, RAM read and emit per evicted entry;
// at most 16 records per sweep; each waits on the RAM's registered read port.
// A stalled record holds the sequencer; no new word is taken until done.
// Reset clears valid bits and sets the timeout to 300; no clearing pass.
module tcp_flow_tracking_table_core #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    tflt_pkt_if.sink    pkt,
    tflt_rec_if.source  rec,
    tflt_cfg_if.sink    cfg
);

    localparam int IDXW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    tflt_pkg::ctrl_cmd_t cmd;
    tflt_pkg::ctrl_sts_t sts;
    logic                in_ready;

    assign pkt.ready = in_ready;

    tflt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (pkt.valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    tflt_dp #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .IDXW        (IDXW)
    ) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .pkt   (pkt),
        .rec   (rec),
        .cfg   (cfg),
        .cmd   (cmd),
        .sts   (sts)
    );

endmodule

// ===== verif/tcp_flow_tracking_table_core_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcp_flow_tracking_table_core_checker
// Watches the packet, record and timeout channels. Keeps its own flow table,
// predicts the records of each accepted word and compares them in order.
// ----------------------------------------------------------------------------
module tcp_flow_tracking_table_core_checker #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic clk,
    input  logic rst_n,
    tflt_pkt_if  pkt,
    tflt_rec_if  rec,
    tflt_cfg_if  cfg,
    output int   error_count,
    output int   pending_records
);

    typedef struct packed {
        logic [2:0]  kind;
        logic [3:0]  slot;
        logic [31:0] sa;
        logic [31:0] da;
        logic [15:0] sp;
        logic [15:0] dp;
        logic        active;
        logic [31:0] spk;
        logic [31:0] rpk;
        logic [63:0] sb;
        logic [63:0] rb;
        logic        last;
    } flow_record_t;

    flow_record_t              record_queue[$];
    logic [31:0]               timeout_reg;
    logic                      flow_valid [TABLE_DEPTH];
    tflt_pkg::entry_t          flow_entry [TABLE_DEPTH];
    logic [31:0]               flow_seen  [TABLE_DEPTH];

    function automatic flow_record_t entry_record(logic [2:0] kind, int s);
        flow_record_t r;
        r.kind   = kind;
        r.slot   = s[3:0];
        r.sa     = flow_entry[s].sa;
        r.da     = flow_entry[s].da;
        r.sp     = flow_entry[s].sp;
        r.dp     = flow_entry[s].dp;
        r.active = flow_entry[s].active;
        r.spk    = flow_entry[s].spk;
        r.rpk    = flow_entry[s].rpk;
        r.sb     = flow_entry[s].sb;
        r.rb     = flow_entry[s].rb;
        r.last   = 1'b0;
        return r;
    endfunction

    task automatic track_word();
        flow_record_t r;
        int           s;
        int           n;
        logic [31:0]  now;
        s   = -1;
        n   = 0;
        now = pkt.now_seconds;
        if (pkt.command == tflt_pkg::CMD_SWEEP) begin
            for (int i = 0; i < TABLE_DEPTH && n < tflt_pkg::MAX_RESULTS; i++) begin
                if (flow_valid[i] && (now - flow_seen[i]) > timeout_reg) begin
                    r = entry_record(tflt_pkg::KIND_TIMEOUT, i);
                    record_queue.push_back(r);
                    flow_valid[i] = 1'b0;
                    n++;
                end
            end
            if (n > 0)
                record_queue[$].last = 1'b1;
            return;
        end
        for (int i = 0; i < TABLE_DEPTH && s < 0; i++) begin
            if (flow_valid[i] &&
                ((flow_entry[i].sa == pkt.source_address &&
                  flow_entry[i].sp == pkt.source_port &&
                  flow_entry[i].da == pkt.destination_address &&
                  flow_entry[i].dp == pkt.destination_port) ||
                 (flow_entry[i].sa == pkt.destination_address &&
                  flow_entry[i].sp == pkt.destination_port &&
                  flow_entry[i].da == pkt.source_address &&
                  flow_entry[i].dp == pkt.source_port)))
                s = i;
        end
        if (s < 0) begin
            r      = '0;
            r.sa   = pkt.source_address;
            r.da   = pkt.destination_address;
            r.sp   = pkt.source_port;
            r.dp   = pkt.destination_port;
            r.last = 1'b1;
            if (!pkt.tcp_flag_bits[tflt_pkg::FLAG_SYN_BIT]) begin
                r.kind = tflt_pkg::KIND_UNTRACKED;
                record_queue.push_back(r);
                return;
            end
            for (int i = 0; i < TABLE_DEPTH && s < 0; i++)
                if (!flow_valid[i])
                    s = i;
            if (s < 0) begin
                r.kind = tflt_pkg::KIND_FULL;
                record_queue.push_back(r);
                return;
            end
            flow_valid[s]        = 1'b1;
            flow_entry[s]        = '0;
            flow_entry[s].sa     = pkt.source_address;
            flow_entry[s].da     = pkt.destination_address;
            flow_entry[s].sp     = pkt.source_port;
            flow_entry[s].dp     = pkt.destination_port;
            flow_entry[s].active = !pkt.tcp_flag_bits[tflt_pkg::FLAG_ACK_BIT];
        end
        flow_seen[s] = now;
        if (flow_entry[s].sa == pkt.source_address && flow_entry[s].sp == pkt.source_port)
        begin
            flow_entry[s].spk = flow_entry[s].spk + 32'd1;
            flow_entry[s].sb  = flow_entry[s].sb + 64'(pkt.ip_total_length);
        end else begin
            flow_entry[s].rpk = flow_entry[s].rpk + 32'd1;
            flow_entry[s].rb  = flow_entry[s].rb + 64'(pkt.ip_total_length);
        end
        if (pkt.tcp_flag_bits[tflt_pkg::FLAG_FIN_BIT] ||
            pkt.tcp_flag_bits[tflt_pkg::FLAG_RST_BIT]) begin
            r = entry_record(tflt_pkg::KIND_CLOSED, s);
            flow_valid[s] = 1'b0;
        end else begin
            r = entry_record(tflt_pkg::KIND_UPDATED, s);
        end
        r.last = 1'b1;
        record_queue.push_back(r);
    endtask

    task automatic check_record();
        flow_record_t got;
        flow_record_t want;
        got = {rec.record_kind, rec.slot_index, rec.flow_source_address,
               rec.flow_destination_address, rec.flow_source_port,
               rec.flow_destination_port, rec.opened_actively,
               rec.sent_packet_count, rec.received_packet_count,
               rec.sent_byte_count, rec.received_byte_count, rec.last_in_run};
        if (record_queue.size() == 0) begin
            $display("%0t: unexpected record, expected none, actual %h", $time, got);
            error_count++;
            return;
        end
        want = record_queue.pop_front();
        if (got.kind !== want.kind) begin
            $display("%0t: kind expected %0d actual %0d", $time, want.kind, got.kind);
            error_count++;
        end
        if (got.slot !== want.slot) begin
            $display("%0t: slot expected %0d actual %0d", $time, want.slot, got.slot);
            error_count++;
        end
        if (got.sa !== want.sa || got.da !== want.da || got.sp !== want.sp ||
            got.dp !== want.dp) begin
            $display("%0t: tuple expected %h %h %h %h actual %h %h %h %h", $time,
                     want.sa, want.da, want.sp, want.dp, got.sa, got.da, got.sp, got.dp);
            error_count++;
        end
        if (got.active !== want.active) begin
            $display("%0t: active expected %b actual %b", $time, want.active, got.active);
            error_count++;
        end
        if (got.spk !== want.spk || got.rpk !== want.rpk) begin
            $display("%0t: packets expected %h %h actual %h %h", $time,
                     want.spk, want.rpk, got.spk, got.rpk);
            error_count++;
        end
        if (got.sb !== want.sb || got.rb !== want.rb) begin
            $display("%0t: bytes expected %h %h actual %h %h", $time,
                     want.sb, want.rb, got.sb, got.rb);
            error_count++;
        end
        if (got.last !== want.last) begin
            $display("%0t: last expected %b actual %b", $time, want.last, got.last);
            error_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            error_count = 0;
            timeout_reg = tflt_pkg::DEFAULT_TIMEOUT;
            record_queue.delete();
            pending_records = 0;
            for (int i = 0; i < TABLE_DEPTH; i++)
                flow_valid[i] = 1'b0;
        end else begin
            if (rec.valid && rec.ready)
                check_record();
            if (cfg.valid && cfg.ready)
                timeout_reg = cfg.idle_timeout_seconds;
            if (pkt.valid && pkt.ready)
                track_word();
            pending_records = record_queue.size();
        end
    end

endmodule

// ===== verif/tcp_flow_tracking_table_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcp_flow_tracking_table_core_tb
// Drives packet and sweep words and timeout writes into the flow table with
// random gaps and record stalls; the checker predicts and compares records.
// ----------------------------------------------------------------------------
module tcp_flow_tracking_table_core_tb;

    localparam int WATCHDOG_LIMIT = 20000;

    logic clk;
    logic rst_n;
    int   error_count;
    int   pending_records;
    int   idle_cycles;
    bit   stall_enable;

    tflt_pkt_if pkt ();
    tflt_rec_if rec ();
    tflt_cfg_if cfg ();

    tcp_flow_tracking_table_core #(.TABLE_DEPTH(16)) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .pkt   (pkt),
        .rec   (rec),
        .cfg   (cfg)
    );

    tcp_flow_tracking_table_core_checker #(.TABLE_DEPTH(16)) u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .pkt             (pkt),
        .rec             (rec),
        .cfg             (cfg),
        .error_count     (error_count),
        .pending_records (pending_records)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic int gap_length();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(10, 40);
        return $urandom_range(0, 2);
    endfunction

    // record-side stalls
    always @(negedge clk) begin
        if (!stall_enable)
            rec.ready <= 1'b1;
        else if ($urandom_range(0, 19) == 0)
            rec.ready <= 1'b0;
        else if ($urandom_range(0, 2) == 0)
            rec.ready <= 1'b1;
    end

    always @(posedge clk) begin
        if ((pkt.valid && pkt.ready) || (rec.valid && rec.ready) ||
            (cfg.valid && cfg.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // called at a falling edge; valid stays high into the next word when
    // there is no gap
    task automatic send_word(logic cmd, logic [31:0] now, logic [31:0] sa,
                             logic [31:0] da, logic [15:0] sp, logic [15:0] dp,
                             logic [15:0] len, logic [7:0] flags);
        int g;
        g = stall_enable ? gap_length() : 0;
        if (g > 0) begin
            pkt.valid <= 1'b0;
            repeat (g) @(negedge clk);
        end
        pkt.valid               <= 1'b1;
        pkt.command             <= cmd;
        pkt.now_seconds         <= now;
        pkt.source_address      <= sa;
        pkt.destination_address <= da;
        pkt.source_port         <= sp;
        pkt.destination_port    <= dp;
        pkt.ip_total_length     <= len;
        pkt.tcp_flag_bits       <= flags;
        @(posedge clk);
        while (!pkt.ready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain();
        pkt.valid <= 1'b0;
        while (pending_records != 0) @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic write_timeout(logic [31:0] value);
        drain();
        cfg.valid                <= 1'b1;
        cfg.idle_timeout_seconds <= value;
        @(posedge clk);
        while (!cfg.ready) @(posedge clk);
        @(negedge clk);
        cfg.valid <= 1'b0;
    endtask

    // mostly well-formed flows from a small pool so lookups hit
    task automatic random_phase(int count, logic [31:0] base_time);
        logic [31:0] now;
        logic [31:0] a;
        logic [31:0] b;
        logic [15:0] p;
        logic [15:0] q;
        logic [7:0]  flags;
        int          k;
        now = base_time;
        for (int i = 0; i < count; i++) begin
            now = now + $urandom_range(0, 120);
            k   = $urandom_range(0, 23);
            a   = (k % 3 == 0) ? $urandom() : 32'h0A00_0000 + (k % 12);
            b   = (k % 3 == 0) ? $urandom() : 32'hC0A8_0000 + (k % 5);
            p   = (k % 3 == 0) ? 16'($urandom()) : 16'(1000 + k % 12);
            q   = (k % 3 == 0) ? 16'($urandom()) : 16'(80 + k % 3);
            case ($urandom_range(0, 9))
                0, 1:    flags = 8'h02 | ($urandom_range(0, 1) ? 8'h10 : 8'h00);
                2:       flags = 8'h11;
                3:       flags = 8'h04;
                4:       flags = 8'($urandom());
                default: flags = 8'h18;
            endcase
            if ($urandom_range(0, 11) == 0)
                send_word(tflt_pkg::CMD_SWEEP, now, $urandom(), $urandom(),
                          16'($urandom()), 16'($urandom()), 16'($urandom()),
                          8'($urandom()));
            else if ($urandom_range(0, 1))
                send_word(tflt_pkg::CMD_PACKET, now, a, b, p, q, 16'($urandom()), flags);
            else
                send_word(tflt_pkg::CMD_PACKET, now, b, a, q, p, 16'($urandom()), flags);
        end
    endtask

    initial begin
        rst_n        = 1'b0;
        stall_enable = 1'b0;
        idle_cycles  = 0;
        pkt.valid = 1'b0; pkt.command = tflt_pkg::CMD_PACKET; pkt.now_seconds = '0;
        pkt.source_address = '0; pkt.destination_address = '0;
        pkt.source_port = '0; pkt.destination_port = '0;
        pkt.ip_total_length = '0; pkt.tcp_flag_bits = '0;
        rec.ready = 1'b1;
        cfg.valid = 1'b0; cfg.idle_timeout_seconds = '0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: untracked, open, symmetric, both directions, close, full
        send_word(tflt_pkg::CMD_PACKET, 32'd0, 32'h0, 32'h0, 16'h0, 16'h0, 16'h0, 8'h00);
        send_word(tflt_pkg::CMD_PACKET, 32'd10, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF,
                  16'hFFFF, 16'hFFFF, 8'h02);
        send_word(tflt_pkg::CMD_PACKET, 32'd11, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF,
                  16'hFFFF, 16'hFFFF, 8'hE8);
        send_word(tflt_pkg::CMD_PACKET, 32'd12, 32'h0102_0304, 32'h0506_0708, 16'd1234,
                  16'd80, 16'd60, 8'h12);
        send_word(tflt_pkg::CMD_PACKET, 32'd13, 32'h0506_0708, 32'h0102_0304, 16'd80,
                  16'd1234, 16'd1500, 8'h10);
        send_word(tflt_pkg::CMD_PACKET, 32'd14, 32'h0506_0708, 32'h0102_0304, 16'd80,
                  16'd1234, 16'd40, 8'h11);
        send_word(tflt_pkg::CMD_PACKET, 32'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF,
                  16'hFFFF, 16'd1, 8'h04);
        for (int i = 0; i < 17; i++)
            send_word(tflt_pkg::CMD_PACKET, 32'd20, 32'h0A00_0100 + i, 32'h0B00_0000,
                      16'(i), 16'd443, 16'(100 + i), 8'h02);
        send_word(tflt_pkg::CMD_SWEEP, 32'd320, '0, '0, '0, '0, '0, 8'h00);
        send_word(tflt_pkg::CMD_SWEEP, 32'd321, '1, '1, '1, '1, '1, 8'hFF);
        write_timeout(32'd0);
        send_word(tflt_pkg::CMD_SWEEP, 32'd20, '0, '0, '0, '0, '0, 8'h00);
        write_timeout(32'd0);
        send_word(tflt_pkg::CMD_SWEEP, 32'd19, '0, '0, '0, '0, '0, 8'h00);

        stall_enable = 1'b1;
        write_timeout(32'd60);
        random_phase(80, 32'd1000);
        write_timeout(32'hFFFF_FFFF);
        random_phase(60, 32'hFFFF_F000);
        write_timeout(32'd0);
        random_phase(60, 32'd5);
        write_timeout(32'd300);
        random_phase(60, 32'h8000_0000);
        send_word(tflt_pkg::CMD_SWEEP, 32'h7000_0000, '0, '0, '0, '0, '0, 8'h00);

        drain();
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/tflt_pkg.sv
rtl/core/tflt_if.sv
rtl/core/tflt_ram.sv
rtl/core/tflt_ctrl.sv
rtl/core/tflt_dp.sv
rtl/core/tcp_flow_tracking_table_core.sv
verif/tcp_flow_tracking_table_core_checker.sv
verif/tcp_flow_tracking_table_core_tb.sv
